@@ sv/nqse_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqse_pkg
// Shared types and constants for the N-queens solution enumerator.
// ----------------------------------------------------------------------------
package nqse_pkg;

   localparam int COL_W   = 4;    // bits of one row's column index
   localparam int COUNT_W = 10;   // solution count width
   localparam int BSIZE_W = 4;    // board_size register width
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
   localparam logic [BSIZE_W-1:0] BOARD_SIZE_RESET = 4'd10;

   // register index, as decoded from paddr[2]
   localparam logic REG_BOARD_SIZE = 1'b0;

   // per-row command from the search controller
   typedef struct packed {
      logic clear;   // empty the row (restart or reconfigure)
      logic place;   // set the queen to the offered column
      logic drop;    // remove the queen (backtrack)
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ sv/nqse_row_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nqse_row_cell
// One board row: holds its queen as a one-hot column and passes the attack
// masks (column, up-diagonal, down-diagonal) to the row above, registered.
// ----------------------------------------------------------------------------
module nqse_row_cell
   import nqse_pkg::*;
#(
   parameter int MAX_SIZE = 10
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire cell_ctrl_type       ctrl,
   input  wire logic [MAX_SIZE-1:0] place_col,
   input  wire logic [MAX_SIZE-1:0] in_col,
   input  wire logic [MAX_SIZE-1:0] in_up,
   input  wire logic [MAX_SIZE-1:0] in_dn,
   output logic      [MAX_SIZE-1:0] out_col,
   output logic      [MAX_SIZE-1:0] out_up,
   output logic      [MAX_SIZE-1:0] out_dn,
   output logic      [MAX_SIZE-1:0] free,
   output logic      [MAX_SIZE-1:0] queen,
   output logic      [COL_W-1:0]    queen_idx
);

   logic [MAX_SIZE-1:0] queen_ff, queen_in;
   logic [MAX_SIZE-1:0] col_ff, up_ff, dn_ff;
   logic [MAX_SIZE-1:0] up_mark, dn_mark;

   always_comb begin
      queen_in = queen_ff;
      if (ctrl.clear || ctrl.drop) begin
         queen_in = '0;
      end else if (ctrl.place) begin
         queen_in = place_col;
      end
   end

   // diagonals move one column per row
   assign up_mark = in_up | queen_in;
   assign dn_mark = in_dn | queen_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         queen_ff <= '0;
         col_ff   <= '0;
         up_ff    <= '0;
         dn_ff    <= '0;
      end else begin
         queen_ff <= queen_in;
         col_ff   <= in_col | queen_in;
         up_ff    <= {up_mark[MAX_SIZE-2:0], 1'b0};
         dn_ff    <= {1'b0, dn_mark[MAX_SIZE-1:1]};
      end
   end

   always_comb begin
      queen_idx = '0;
      for (int i = 0; i < MAX_SIZE; i++) begin
         if (queen_ff[i]) begin
            queen_idx = queen_idx | COL_W'(i);
         end
      end
   end

   assign free    = ~(in_col | in_up | in_dn);
   assign queen   = queen_ff;
   assign out_col = col_ff;
   assign out_up  = up_ff;
   assign out_dn  = dn_ff;

`ifndef ASSERT_OFF
   a_queen_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(queen_ff))
      else $error("row holds more than one queen");

   a_place_safe: assert property (@(posedge clock) disable iff (reset)
      ctrl.place |-> ($onehot(place_col) && ((place_col & ~free) == '0)))
      else $error("queen placed on an attacked square");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (ctrl.clear || ctrl.drop) |=> (queen_ff == '0))
      else $error("row still holds a queen after clear or drop");
`endif

endmodule
`default_nettype wire

@@ sv/n_queens_solution_enumerator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator
// Depth-first N-queens search over a chain of row cells; each request
// returns the next solution, or not-found once the search is exhausted.
// ----------------------------------------------------------------------------
// Flow: an accepted request enters S_SEARCH, where each step places a queen,
// backtracks a row, or ends the search; S_FINISH then registers rsp_valid.
// An exhausted search goes from S_IDLE straight to S_FINISH. One request at a
// time; a stalled result holds the search in its last state.
// Reset: board_size returns to 10, the board, count and exhausted flag clear.
// A board_size write in S_IDLE clears the search like a restart; others are dropped.
module n_queens_solution_enumerator
   import nqse_pkg::*;
#(
   parameter int MAX_SIZE = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // requests
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic                    req_restart,
   // results
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic                         rsp_found,
   output logic [COL_W*MAX_SIZE-1:0]    rsp_placement,
   output logic [COUNT_W-1:0]           rsp_solutions_so_far,
   // configuration
   input  wire logic                    csr_psel,
   input  wire logic                    csr_penable,
   input  wire logic                    csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]   csr_pwdata,
   output logic [CSR_DATA_W-1:0]        csr_prdata,
   output logic                         csr_pready
);

   localparam int ROW_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int DEPTH_W = $clog2(MAX_SIZE + 1);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_FINISH} state_type;

   state_type                 state_ff, state_in;
   logic [BSIZE_W-1:0]        board_size_ff, board_size_in;
   logic [DEPTH_W-1:0]        depth_ff, depth_in;
   logic [MAX_SIZE-1:0]       allow_ff, allow_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic                      exhausted_ff, exhausted_in;
   logic                      hit_ff, hit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic [COL_W*MAX_SIZE-1:0] rsp_placement_ff, rsp_placement_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                      cfg_wr;
   logic [BSIZE_W-1:0]        n_eff;
   logic [DEPTH_W-1:0]        n_depth;
   logic [MAX_SIZE-1:0]       valid_cols;
   logic                      at_full;
   logic [MAX_SIZE-1:0]       cur_free, cand, pick;
   logic [DEPTH_W-1:0]        prev_row;
   logic [MAX_SIZE-1:0]       prev_q;
   logic                      clear_en, place_en, pop_en;
   logic                      slot_free;
   logic [COL_W*MAX_SIZE-1:0] packed_board;

   logic [MAX_SIZE-1:0] col_link  [MAX_SIZE];
   logic [MAX_SIZE-1:0] up_link   [MAX_SIZE];
   logic [MAX_SIZE-1:0] dn_link   [MAX_SIZE];
   logic [MAX_SIZE-1:0] free_vec  [MAX_SIZE];
   logic [MAX_SIZE-1:0] queen_vec [MAX_SIZE];
   logic [COL_W-1:0]    idx_vec   [MAX_SIZE];

   // ---- row chain ----
   for (genvar r = 0; r < MAX_SIZE; r++) begin : g_row
      cell_ctrl_type       ctrl;
      logic [MAX_SIZE-1:0] in_col, in_up, in_dn;

      assign ctrl.clear = clear_en;
      assign ctrl.place = place_en && (depth_ff == DEPTH_W'(r));
      assign ctrl.drop  = pop_en && (prev_row == DEPTH_W'(r));

      if (r == 0) begin : g_base
         assign in_col = '0;
         assign in_up  = '0;
         assign in_dn  = '0;
      end else begin : g_link
         assign in_col = col_link[r-1];
         assign in_up  = up_link[r-1];
         assign in_dn  = dn_link[r-1];
      end

      nqse_row_cell #(.MAX_SIZE(MAX_SIZE)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .place_col (pick),
         .in_col    (in_col),
         .in_up     (in_up),
         .in_dn     (in_dn),
         .out_col   (col_link[r]),
         .out_up    (up_link[r]),
         .out_dn    (dn_link[r]),
         .free      (free_vec[r]),
         .queen     (queen_vec[r]),
         .queen_idx (idx_vec[r])
      );
   end

   always_comb begin
      packed_board = '0;
      for (int r = 0; r < MAX_SIZE; r++) begin
         packed_board[r*COL_W +: COL_W] = idx_vec[r];
      end
   end

   // ---- search control ----
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_BOARD_SIZE);

   always_comb begin
      if (board_size_ff == '0) begin
         n_eff = BSIZE_W'(1);
      end else if (board_size_ff > BSIZE_W'(MAX_SIZE)) begin
         n_eff = BSIZE_W'(MAX_SIZE);
      end else begin
         n_eff = board_size_ff;
      end
   end

   assign n_depth = DEPTH_W'(n_eff);

   always_comb begin
      for (int i = 0; i < MAX_SIZE; i++) begin
         valid_cols[i] = (BSIZE_W'(i) < n_eff);
      end
   end

   assign at_full  = (depth_ff == n_depth);
   assign cur_free = free_vec[depth_ff[ROW_W-1:0]];
   assign cand     = cur_free & valid_cols & allow_ff;
   assign pick     = cand & (~cand + MAX_SIZE'(1));
   assign prev_row = depth_ff - DEPTH_W'(1);
   assign prev_q   = queen_vec[prev_row[ROW_W-1:0]];
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in         = state_ff;
      board_size_in    = board_size_ff;
      depth_in         = depth_ff;
      allow_in         = allow_ff;
      count_in         = count_ff;
      exhausted_in     = exhausted_ff;
      hit_in           = hit_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_found_in     = rsp_found_ff;
      rsp_placement_in = rsp_placement_ff;
      rsp_count_in     = rsp_count_ff;
      clear_en         = 1'b0;
      place_en         = 1'b0;
      pop_en           = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cfg_wr) begin
               board_size_in = csr_pwdata[BSIZE_W-1:0];
               clear_en      = 1'b1;
               depth_in      = '0;
               allow_in      = '1;
               count_in      = '0;
               exhausted_in  = 1'b0;
            end else if (req_valid) begin
               if (req_restart) begin
                  clear_en     = 1'b1;
                  depth_in     = '0;
                  allow_in     = '1;
                  count_in     = '0;
                  exhausted_in = 1'b0;
               end
               if (req_restart || !exhausted_ff) begin
                  state_in = S_SEARCH;
               end else begin
                  hit_in   = 1'b0;
                  state_in = S_FINISH;
               end
            end
         end
         S_SEARCH: begin
            if (at_full || cand == '0) begin
               if (!at_full && depth_ff == '0) begin
                  exhausted_in = 1'b1;
                  hit_in       = 1'b0;
                  state_in     = S_FINISH;
               end else begin
                  // backtrack: resume the row below just past its queen
                  pop_en   = 1'b1;
                  allow_in = ~(prev_q | (prev_q - MAX_SIZE'(1)));
                  depth_in = prev_row;
               end
            end else begin
               place_en = 1'b1;
               allow_in = '1;
               depth_in = depth_ff + DEPTH_W'(1);
               if (depth_ff + DEPTH_W'(1) == n_depth) begin
                  hit_in = 1'b1;
                  if (count_ff != COUNT_MAX) begin
                     count_in = count_ff + COUNT_W'(1);
                  end
                  state_in = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_found_in     = hit_ff;
               rsp_placement_in = hit_ff ? packed_board : '0;
               rsp_count_in     = count_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         board_size_ff <= BOARD_SIZE_RESET;
         depth_ff      <= '0;
         allow_ff      <= '1;
         count_ff      <= '0;
         exhausted_ff  <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         board_size_ff <= board_size_in;
         depth_ff      <= depth_in;
         allow_ff      <= allow_in;
         count_ff      <= count_in;
         exhausted_ff  <= exhausted_in;
         hit_ff        <= hit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_found_ff     <= rsp_found_in;
      rsp_placement_ff <= rsp_placement_in;
      rsp_count_ff     <= rsp_count_in;
   end

   assign req_ready            = (state_ff == S_IDLE) && !cfg_wr;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_found_ff;
   assign rsp_placement        = rsp_placement_ff;
   assign rsp_solutions_so_far = rsp_count_ff;
   assign csr_pready           = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_BOARD_SIZE)
                       ? CSR_DATA_W'(board_size_ff) : '0;

`ifndef ASSERT_OFF
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= n_depth)
      else $error("search depth beyond board size");

   a_exhausted_empty: assert property (@(posedge clock) disable iff (reset)
      exhausted_ff |-> (depth_ff == '0))
      else $error("exhausted with queens still on the board");

   a_found_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (rsp_count_ff != '0))
      else $error("solution returned with zero count");
`endif

endmodule
`default_nettype wire
